FILE: src/bpa_pkg.sv
package bpa_pkg;

   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_MEMORY = 2'd1;
   localparam logic [1:0] ST_BAD_ORDER = 2'd2;
   localparam logic [1:0] ST_BAD_PAGE  = 2'd3;

   localparam logic CSR_BASE_FRAME  = 1'b0;
   localparam logic CSR_REGION_SIZE = 1'b1;

   localparam logic [12:0] REGION_SIZE_RESET = 13'd4096;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  req_order;
      logic [28:0] page_frame;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [28:0] alloc_frame;
      logic [12:0] free_count;
   } rsp_type;

   typedef struct packed {
      logic       is_head;
      logic       is_free;
      logic [3:0] order;
   } page_entry_type;

endpackage

FILE: src/bpa_ram.sv
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/bpa_ctrl.sv
module bpa_ctrl #(
   parameter int NUM_PAGES   = 4096,
   parameter int MAX_ORDER_P = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bpa_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bpa_pkg::rsp_type              rsp_data,
   input  logic [27:0]                   base_frame,
   input  logic [12:0]                   region_size,
   output logic [$clog2(NUM_PAGES)-1:0]  rd_addr,
   output logic                          page_we,
   output logic [$clog2(NUM_PAGES)-1:0]  page_waddr,
   output bpa_pkg::page_entry_type       page_wdata,
   input  bpa_pkg::page_entry_type       page_rdata,
   output logic                          next_we,
   output logic [$clog2(NUM_PAGES)-1:0]  next_waddr,
   output logic [$clog2(NUM_PAGES):0]    next_wdata,
   input  logic [$clog2(NUM_PAGES):0]    next_rdata,
   output logic                          prev_we,
   output logic [$clog2(NUM_PAGES)-1:0]  prev_waddr,
   output logic [$clog2(NUM_PAGES):0]    prev_wdata,
   input  logic [$clog2(NUM_PAGES):0]    prev_rdata
);

   localparam int PW   = $clog2(NUM_PAGES);
   localparam int CW   = PW + 1;
   localparam int LKW  = PW + 1;
   localparam int LW   = (CW > 13) ? CW : 13;
   localparam int SW   = ((CW > MAX_ORDER_P + 1) ? CW : MAX_ORDER_P + 1) + 1;
   localparam int NL   = MAX_ORDER_P + 1;
   localparam int OIW  = $clog2(NL);
   localparam logic [LKW-1:0] NIL = {1'b1, {PW{1'b0}}};
   localparam logic [3:0] MAX_ORD = 4'(MAX_ORDER_P);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_CARVE, S_PUSH1, S_PUSH2, S_A_SRCH, S_A_UNL, S_A_SPL,
      S_F_RD, S_F_CHK, S_M_RD, S_M_CHK, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [3:0]       ord_ff, ord_in;
   logic [3:0]       c_ff, c_in;
   logic [28:0]      pf_ff, pf_in;
   logic [CW-1:0]    pg_ff, pg_in;
   logic [CW-1:0]    blk_end_ff, blk_end_in;
   logic [LKW-1:0]   hd_ff, hd_in;
   logic [27:0]      base_ff, base_in;
   logic [CW-1:0]    rp_ff, rp_in;
   logic [CW-1:0]    free_ff, free_in;
   logic [1:0]       status_ff, status_in;
   logic [28:0]      frame_ff, frame_in;
   logic             init_ff, init_in;
   logic [LKW-1:0]   heads_ff [NL];
   logic [LKW-1:0]   heads_in [NL];
   logic             rsp_valid_ff, rsp_valid_in;
   bpa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             found;
   logic [3:0]       found_c;
   logic [LKW-1:0]   found_head;
   logic [3:0]       carve_ord;
   logic [SW-1:0]    buddy;
   logic             merge_try;
   logic [28:0]      diff;
   logic             in_rgn;
   logic [CW-1:0]    sz_ord;
   logic [CW-1:0]    lo_pg;
   logic [CW-1:0]    hi_pg;
   logic [3:0]       cm;

   always_comb begin
      found      = 1'b0;
      found_c    = '0;
      found_head = NIL;
      for (int k = 0; k < NL; k++) begin
         if (!found && (4'(k) >= ord_ff) && !heads_ff[k][PW]) begin
            found      = 1'b1;
            found_c    = 4'(k);
            found_head = heads_ff[k];
         end
      end
   end

   always_comb begin
      carve_ord = '0;
      for (int k = 0; k < MAX_ORDER_P; k++) begin
         if (((SW'(pg_ff) & ((SW'(1) << (k + 1)) - SW'(1))) == '0) &&
             ((SW'(pg_ff) + (SW'(1) << (k + 1))) <= SW'(rp_ff))) begin
            carve_ord = carve_ord + 4'd1;
         end
      end
   end

   assign buddy     = SW'(pg_ff) ^ (SW'(1) << ord_ff);
   assign merge_try = (ord_ff < MAX_ORD) && (buddy < SW'(rp_ff));
   assign diff      = pf_ff - {1'b0, base_ff};
   assign in_rgn    = (pf_ff >= {1'b0, base_ff}) && (diff < 29'(rp_ff));
   assign sz_ord    = CW'(1) << ord_ff;
   assign lo_pg     = (CW'(buddy) < pg_ff) ? CW'(buddy) : pg_ff;
   assign hi_pg     = (CW'(buddy) < pg_ff) ? pg_ff : CW'(buddy);
   assign cm        = c_ff - 4'd1;

   always_comb begin
      state_in     = state_ff;
      ord_in       = ord_ff;
      c_in         = c_ff;
      pf_in        = pf_ff;
      pg_in        = pg_ff;
      blk_end_in   = blk_end_ff;
      hd_in        = hd_ff;
      base_in      = base_ff;
      rp_in        = rp_ff;
      free_in      = free_ff;
      status_in    = status_ff;
      frame_in     = frame_ff;
      init_in      = init_ff;
      heads_in     = heads_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      rd_addr    = pg_ff[PW-1:0];
      page_we    = 1'b0;
      page_waddr = pg_ff[PW-1:0];
      page_wdata = '0;
      next_we    = 1'b0;
      next_waddr = pg_ff[PW-1:0];
      next_wdata = NIL;
      prev_we    = 1'b0;
      prev_waddr = pg_ff[PW-1:0];
      prev_wdata = NIL;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ord_in    = req_data.req_order;
               pf_in     = req_data.page_frame;
               status_in = bpa_pkg::ST_OK;
               frame_in  = '0;
               case (req_data.opcode)
                  bpa_pkg::OP_INIT: state_in = S_INIT;
                  bpa_pkg::OP_ALLOC: begin
                     if (req_data.req_order > MAX_ORD) begin
                        status_in = bpa_pkg::ST_BAD_ORDER;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_A_SRCH;
                     end
                  end
                  bpa_pkg::OP_FREE: begin
                     if (req_data.req_order > MAX_ORD) begin
                        status_in = bpa_pkg::ST_BAD_ORDER;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_F_RD;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_INIT: begin
            base_in = base_frame;
            rp_in   = (LW'(region_size) < LW'(NUM_PAGES)) ? CW'(region_size)
                                                           : CW'(NUM_PAGES);
            for (int k = 0; k < NL; k++) begin
               heads_in[k] = NIL;
            end
            free_in    = '0;
            pg_in      = '0;
            blk_end_in = '0;
            init_in    = 1'b1;
            state_in   = S_CARVE;
         end
         S_CARVE: begin
            if (pg_ff >= rp_ff) begin
               init_in  = 1'b0;
               state_in = S_DONE;
            end else if (pg_ff == blk_end_ff) begin
               ord_in     = carve_ord;
               blk_end_in = pg_ff + (CW'(1) << carve_ord);
               free_in    = free_ff + (CW'(1) << carve_ord);
               state_in   = S_PUSH1;
            end else begin
               page_we = 1'b1;
               pg_in   = pg_ff + CW'(1);
            end
         end
         S_PUSH1: begin
            hd_in      = heads_ff[ord_ff[OIW-1:0]];
            next_we    = 1'b1;
            next_wdata = heads_ff[ord_ff[OIW-1:0]];
            prev_we    = 1'b1;
            page_we    = 1'b1;
            page_wdata = '{is_head: 1'b1, is_free: 1'b1, order: ord_ff};
            heads_in[ord_ff[OIW-1:0]] = LKW'(pg_ff);
            state_in   = S_PUSH2;
         end
         S_PUSH2: begin
            if (!hd_ff[PW]) begin
               prev_we    = 1'b1;
               prev_waddr = hd_ff[PW-1:0];
               prev_wdata = LKW'(pg_ff);
            end
            if (init_ff) begin
               pg_in    = pg_ff + CW'(1);
               state_in = S_CARVE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_A_SRCH: begin
            if (!found) begin
               status_in = bpa_pkg::ST_NO_MEMORY;
               state_in  = S_DONE;
            end else begin
               c_in     = found_c;
               pg_in    = CW'(found_head);
               rd_addr  = found_head[PW-1:0];
               state_in = S_A_UNL;
            end
         end
         S_A_UNL: begin
            heads_in[c_ff[OIW-1:0]] = next_rdata;
            if (!next_rdata[PW]) begin
               prev_we    = 1'b1;
               prev_waddr = next_rdata[PW-1:0];
               prev_wdata = NIL;
            end
            state_in = S_A_SPL;
         end
         S_A_SPL: begin
            if (c_ff > ord_ff) begin
               next_we    = 1'b1;
               next_waddr = PW'(pg_ff | (CW'(1) << cm));
               prev_we    = 1'b1;
               prev_waddr = PW'(pg_ff | (CW'(1) << cm));
               page_we    = 1'b1;
               page_waddr = PW'(pg_ff | (CW'(1) << cm));
               page_wdata = '{is_head: 1'b1, is_free: 1'b1, order: cm};
               heads_in[cm[OIW-1:0]] = LKW'(pg_ff | (CW'(1) << cm));
               c_in       = cm;
            end else begin
               page_we    = 1'b1;
               page_wdata = '{is_head: 1'b1, is_free: 1'b0, order: ord_ff};
               free_in    = free_ff - sz_ord;
               frame_in   = {1'b0, base_ff} + 29'(pg_ff);
               state_in   = S_DONE;
            end
         end
         S_F_RD: begin
            if (!in_rgn) begin
               status_in = bpa_pkg::ST_BAD_PAGE;
               state_in  = S_DONE;
            end else begin
               pg_in    = CW'(diff);
               rd_addr  = diff[PW-1:0];
               state_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            if (!page_rdata.is_head || page_rdata.is_free ||
                page_rdata.order != ord_ff) begin
               status_in = bpa_pkg::ST_BAD_PAGE;
               state_in  = S_DONE;
            end else begin
               free_in  = free_ff + sz_ord;
               state_in = S_M_RD;
            end
         end
         S_M_RD: begin
            rd_addr = buddy[PW-1:0];
            if (merge_try) begin
               state_in = S_M_CHK;
            end else begin
               state_in = S_PUSH1;
            end
         end
         S_M_CHK: begin
            if (page_rdata.is_head && page_rdata.is_free &&
                page_rdata.order == ord_ff) begin
               if (!prev_rdata[PW]) begin
                  next_we    = 1'b1;
                  next_waddr = prev_rdata[PW-1:0];
                  next_wdata = next_rdata;
               end else begin
                  heads_in[ord_ff[OIW-1:0]] = next_rdata;
               end
               if (!next_rdata[PW]) begin
                  prev_we    = 1'b1;
                  prev_waddr = next_rdata[PW-1:0];
                  prev_wdata = prev_rdata;
               end
               page_we    = 1'b1;
               page_waddr = hi_pg[PW-1:0];
               pg_in      = lo_pg;
               ord_in     = ord_ff + 4'd1;
               state_in   = S_M_RD;
            end else begin
               state_in = S_PUSH1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: status_ff, alloc_frame: frame_ff,
                                free_count: 13'(free_ff)};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rp_ff        <= '0;
         free_ff      <= '0;
         base_ff      <= '0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NL; k++) begin
            heads_ff[k] <= NIL;
         end
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         free_ff      <= free_in;
         base_ff      <= base_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
      end
      ord_ff      <= ord_in;
      c_ff        <= c_in;
      pf_ff       <= pf_in;
      pg_ff       <= pg_in;
      blk_end_ff  <= blk_end_in;
      hd_ff       <= hd_in;
      status_ff   <= status_in;
      frame_ff    <= frame_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/buddy_page_allocator.sv
// Binary buddy page allocator.
// req channel: one beat per operation (init, alloc, free); rsp channel: one
// beat per operation with status, allocated frame and free page count.
// csr channel: always ready; sets the base frame and the region size, both
// taken by the next init.
// The time from the accepting edge to rsp_valid is set by the single read
// port of the page and link memories, which serialises each operation:
//   alloc: search, unlink, a step per split; bad order, out of memory end early.
//   free:  range and head checks, a buddy check when the buddy lies in the
//          region below the top order, and a check per merge; bad order,
//          outside the region or not a busy head of that order end early.
//   init:  a step per page of the region plus a push per carved block.
//   unused opcode: no steps beyond the response.
// One operation is in flight at a time; req_ready returns in the cycle the
// result is loaded.
// The next beat is taken even while rsp is stalled; a stalled result holds
// the block in its final step until taken.
// Reset empties the free lists and the region; the page memories are not
// cleared and are rewritten by init. Before the first init every alloc of a
// valid order reports out of memory and every such free reports a bad page.
module buddy_page_allocator #(
   parameter int NUM_PAGES   = 4096,
   parameter int MAX_ORDER_P = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bpa_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [27:0]      csr_data
);

   localparam int PW = $clog2(NUM_PAGES);

   logic [27:0]             base_frame_ff;
   logic [12:0]             region_size_ff;
   logic [PW-1:0]           rd_addr;
   logic                    page_we;
   logic [PW-1:0]           page_waddr;
   bpa_pkg::page_entry_type page_wdata;
   bpa_pkg::page_entry_type page_rdata;
   logic                    next_we;
   logic [PW-1:0]           next_waddr;
   logic [PW:0]             next_wdata;
   logic [PW:0]             next_rdata;
   logic                    prev_we;
   logic [PW-1:0]           prev_waddr;
   logic [PW:0]             prev_wdata;
   logic [PW:0]             prev_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_frame_ff  <= '0;
         region_size_ff <= bpa_pkg::REGION_SIZE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bpa_pkg::CSR_BASE_FRAME:  base_frame_ff  <= csr_data;
            bpa_pkg::CSR_REGION_SIZE: region_size_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   bpa_ctrl #(
      .NUM_PAGES   (NUM_PAGES),
      .MAX_ORDER_P (MAX_ORDER_P)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .base_frame  (base_frame_ff),
      .region_size (region_size_ff),
      .rd_addr     (rd_addr),
      .page_we     (page_we),
      .page_waddr  (page_waddr),
      .page_wdata  (page_wdata),
      .page_rdata  (page_rdata),
      .next_we     (next_we),
      .next_waddr  (next_waddr),
      .next_wdata  (next_wdata),
      .next_rdata  (next_rdata),
      .prev_we     (prev_we),
      .prev_waddr  (prev_waddr),
      .prev_wdata  (prev_wdata),
      .prev_rdata  (prev_rdata)
   );

   bpa_ram #(.WIDTH($bits(bpa_pkg::page_entry_type)), .DEPTH(NUM_PAGES)) u_page_ram (
      .clock (clock),
      .we    (page_we),
      .waddr (page_waddr),
      .wdata (page_wdata),
      .raddr (rd_addr),
      .rdata (page_rdata)
   );

   bpa_ram #(.WIDTH(PW + 1), .DEPTH(NUM_PAGES)) u_next_ram (
      .clock (clock),
      .we    (next_we),
      .waddr (next_waddr),
      .wdata (next_wdata),
      .raddr (rd_addr),
      .rdata (next_rdata)
   );

   bpa_ram #(.WIDTH(PW + 1), .DEPTH(NUM_PAGES)) u_prev_ram (
      .clock (clock),
      .we    (prev_we),
      .waddr (prev_waddr),
      .wdata (prev_wdata),
      .raddr (rd_addr),
      .rdata (prev_rdata)
   );

endmodule

FILE: src/bpa_checker.sv
module bpa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bpa_pkg::rsp_type rsp_data
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != bpa_pkg::ST_OK |-> rsp_data.alloc_frame == '0)
      else $error("frame set on failed op");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while busy");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
